// File: hw/rtl/p2p_pkg.sv
// Package for the planar to palette CMY converter.
// Holds widths, codes, request/result types and the pixel index function.
// No dependencies.
package p2p_pkg;

  localparam int PLANES      = 8;
  localparam int COORD_BITS  = 12;
  localparam int DIM_W       = COORD_BITS + 1;
  localparam int GROUP_PIX   = 8;
  localparam int PIX_W       = $clog2(GROUP_PIX);
  localparam int COUNT_W     = PIX_W + 1;
  localparam int BYTE_W      = 8;
  localparam int PLANE_BUS_W = 64;
  localparam int COLOR_W     = 8;
  localparam int PAL_DEPTH   = 256;
  localparam int PAL_IDX_W   = $clog2(PAL_DEPTH);
  localparam int PAL_W       = 3 * COLOR_W;
  localparam int ADDR_W      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int BW_W        = 13;
  localparam int POS_W       = 12;

  localparam logic [DIM_W-1:0] COORD_MAX = DIM_W'(1) << COORD_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLANE_ORDER     = 3'd0,
    CFG_BLOCK_WIDTH     = 3'd1,
    CFG_BLOCK_HEIGHT    = 3'd2,
    CFG_DEST_X          = 3'd3,
    CFG_DEST_Y          = 3'd4,
    CFG_DEST_LINE_WIDTH = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_GROUP     = 1'b0,
    OP_PAL_WRITE = 1'b1
  } op_e;

  typedef struct packed {
    op_e                    operation;
    logic [PLANE_BUS_W-1:0] plane_bytes;
    logic [PAL_IDX_W-1:0]   palette_index;
    logic [COLOR_W-1:0]     cyan_in;
    logic [COLOR_W-1:0]     magenta_in;
    logic [COLOR_W-1:0]     yellow_in;
  } req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] cyan;
    logic [COLOR_W-1:0] magenta;
    logic [COLOR_W-1:0] yellow;
    logic [ADDR_W-1:0]  dest_address;
    logic               last_of_group;
    logic               last_of_block;
  } res_t;

  // settled configuration, dimensions already clamped
  typedef struct packed {
    logic              plane_order;
    logic [DIM_W-1:0]  block_w;
    logic [DIM_W-1:0]  block_h;
    logic [POS_W-1:0]  dest_x;
    logic [BW_W-1:0]   line_w;
  } cfg_t;

  // pixel in flight between the sequencer and the output stage
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last_of_group;
    logic              last_of_block;
  } pix_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [BW_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = DIM_W'(v);
    if (v == '0) r = DIM_W'(1);
    else if (DIM_W'(v) > COORD_MAX) r = COORD_MAX;
    return r;
  endfunction

  // gather one bit per plane into a palette index, pixel 0 at bit 7
  function automatic logic [PAL_IDX_W-1:0] pixel_index(
    input logic [PLANE_BUS_W-1:0] planes,
    input logic [PIX_W-1:0]       pix,
    input logic                   order
  );
    logic [PAL_IDX_W-1:0] idx;
    logic [BYTE_W-1:0]    byte_v;
    logic [PIX_W-1:0]     bsel;
    logic [PIX_W-1:0]     pos;
    idx = '0;
    bsel = PIX_W'(GROUP_PIX - 1) - pix;
    for (int k = 0; k < PLANES; k++) begin
      byte_v = planes[k*BYTE_W +: BYTE_W];
      pos = order ? PIX_W'(PLANES - 1 - k) : PIX_W'(k);
      idx[pos] = idx[pos] | byte_v[bsel];
    end
    return idx;
  endfunction

endpackage

// File: hw/rtl/p2p_in_if.sv
// Request channel of the planar to palette CMY converter.
// Depends on p2p_pkg for the request type.
interface p2p_in_if;
  logic          valid;
  logic          ready;
  p2p_pkg::req_t req;

  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

// File: hw/rtl/p2p_out_if.sv
// Result channel of the planar to palette CMY converter.
// Depends on p2p_pkg for the result type.
interface p2p_out_if;
  logic          valid;
  logic          ready;
  p2p_pkg::res_t res;

  modport source (output valid, output res, input ready);
  modport sink (input valid, input res, output ready);
endinterface

// File: hw/rtl/p2p_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module p2p_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/p2p_seq.sv
// Position counters and pixel sequencer: walks each group request pixel by pixel,
// issues palette reads and writes. Depends on p2p_pkg.
module p2p_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  p2p_pkg::cfg_t                 cfg_i,
  input  logic                          cnt_clr_i,
  input  logic [p2p_pkg::ADDR_W-1:0]    base_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  p2p_pkg::req_t                 req_i,
  input  logic                          s2_ready_i,
  output logic                          pix_valid_o,
  output p2p_pkg::pix_t                 pix_o,
  output logic                          ram_we_o,
  output logic [p2p_pkg::PAL_IDX_W-1:0] ram_waddr_o,
  output logic [p2p_pkg::PAL_W-1:0]     ram_wdata_o,
  output logic                          ram_re_o,
  output logic [p2p_pkg::PAL_IDX_W-1:0] ram_raddr_o
);

  logic [p2p_pkg::POS_W-1:0]   col_q, col_d;
  logic [p2p_pkg::POS_W-1:0]   row_q, row_d;
  logic [p2p_pkg::ADDR_W-1:0]  roff_q, roff_d;

  logic [p2p_pkg::DIM_W-1:0]   remain;
  logic [p2p_pkg::COUNT_W-1:0] cnt;
  logic [p2p_pkg::DIM_W-1:0]   col_end;
  logic                        row_end;
  logic                        last_row;
  logic                        req_fire;
  logic                        grp_fire;

  logic                             sq_valid_q, sq_valid_d;
  p2p_pkg::op_e                     sq_op_q;
  logic [p2p_pkg::PLANE_BUS_W-1:0]  sq_planes_q;
  logic [p2p_pkg::PIX_W-1:0]        sq_p_q, sq_p_d;
  logic [p2p_pkg::PIX_W-1:0]        sq_last_q;
  logic                             sq_lblk_q;
  logic [p2p_pkg::ADDR_W-1:0]       sq_off_q, sq_off_d;
  logic [p2p_pkg::PAL_IDX_W-1:0]    sq_pidx_q;
  logic [p2p_pkg::PAL_W-1:0]        sq_pdata_q;
  logic                             issue;
  logic                             sq_done;
  logic                             pix_last;

  assign req_fire = req_valid_i && req_ready_o;
  assign grp_fire = req_fire && (req_i.operation == p2p_pkg::OP_GROUP);

  // group geometry at the current position
  assign remain   = cfg_i.block_w - p2p_pkg::DIM_W'(col_q);
  assign cnt      = (remain >= p2p_pkg::DIM_W'(p2p_pkg::GROUP_PIX))
                    ? p2p_pkg::COUNT_W'(p2p_pkg::GROUP_PIX) : remain[p2p_pkg::COUNT_W-1:0];
  assign col_end  = p2p_pkg::DIM_W'(col_q) + p2p_pkg::DIM_W'(cnt);
  assign row_end  = (col_end == cfg_i.block_w);
  assign last_row = (p2p_pkg::DIM_W'(row_q) + p2p_pkg::DIM_W'(1) == cfg_i.block_h);

  // position counters advance once per group
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    roff_d = roff_q;
    if (cnt_clr_i) begin
      col_d  = '0;
      row_d  = '0;
      roff_d = '0;
    end else if (grp_fire) begin
      if (row_end) begin
        col_d = '0;
        if (last_row) begin
          row_d  = '0;
          roff_d = '0;
        end else begin
          row_d  = row_q + p2p_pkg::POS_W'(1);
          roff_d = roff_q + p2p_pkg::ADDR_W'(cfg_i.line_w);
        end
      end else begin
        col_d = col_end[p2p_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      roff_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      roff_q <= roff_d;
    end
  end

  // sequencer stage handshake
  assign issue    = sq_valid_q && ((sq_op_q == p2p_pkg::OP_PAL_WRITE) || s2_ready_i);
  assign pix_last = (sq_p_q == sq_last_q);
  assign sq_done  = issue && ((sq_op_q == p2p_pkg::OP_PAL_WRITE) || pix_last);
  assign req_ready_o = !sq_valid_q || sq_done;

  always_comb begin
    sq_valid_d = sq_valid_q;
    sq_p_d     = sq_p_q;
    sq_off_d   = sq_off_q;
    if (req_fire) begin
      sq_valid_d = 1'b1;
      sq_p_d     = '0;
      sq_off_d   = roff_q + p2p_pkg::ADDR_W'(cfg_i.dest_x) + p2p_pkg::ADDR_W'(col_q);
    end else begin
      if (sq_done) sq_valid_d = 1'b0;
      if (issue) begin
        sq_p_d   = sq_p_q + p2p_pkg::PIX_W'(1);
        sq_off_d = sq_off_q + p2p_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
    end else begin
      sq_valid_q <= sq_valid_d;
    end
  end

  // request payload and walk registers
  always_ff @(posedge clk_i) begin
    sq_p_q   <= sq_p_d;
    sq_off_q <= sq_off_d;
    if (req_fire) begin
      sq_op_q     <= req_i.operation;
      sq_planes_q <= req_i.plane_bytes;
      sq_last_q   <= p2p_pkg::PIX_W'(cnt - p2p_pkg::COUNT_W'(1));
      sq_lblk_q   <= last_row && row_end;
      sq_pidx_q   <= req_i.palette_index;
      sq_pdata_q  <= {req_i.cyan_in, req_i.magenta_in, req_i.yellow_in};
    end
  end

  // palette accesses, one per cycle; reads only while the read stage is ready
  assign ram_we_o    = sq_valid_q && (sq_op_q == p2p_pkg::OP_PAL_WRITE);
  assign ram_waddr_o = sq_pidx_q;
  assign ram_wdata_o = sq_pdata_q;
  assign ram_re_o    = sq_valid_q && (sq_op_q == p2p_pkg::OP_GROUP) && s2_ready_i;
  assign ram_raddr_o = p2p_pkg::pixel_index(sq_planes_q, sq_p_q, cfg_i.plane_order);

  assign pix_valid_o         = ram_re_o;
  assign pix_o.addr          = base_i + sq_off_q;
  assign pix_o.last_of_group = pix_last;
  assign pix_o.last_of_block = pix_last && sq_lblk_q;

endmodule

// File: hw/rtl/p2p_out.sv
// Read-data stage and output register: pairs palette data with pixel info
// and holds results while the receiver stalls. Depends on p2p_pkg.
module p2p_out (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      pix_valid_i,
  input  p2p_pkg::pix_t             pix_i,
  input  logic [p2p_pkg::PAL_W-1:0] rdata_i,
  output logic                      s2_ready_o,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output p2p_pkg::res_t             res_o
);

  logic          s2_valid_q, s2_valid_d;
  p2p_pkg::pix_t s2_pix_q;
  logic          out_valid_q, out_valid_d;
  p2p_pkg::res_t out_res_q;
  logic          out_free;
  logic          s2_move;

  assign out_free   = !out_valid_q || res_ready_i;
  assign s2_move    = s2_valid_q && out_free;
  assign s2_ready_o = !s2_valid_q || out_free;

  // valid flags of both stages
  always_comb begin
    s2_valid_d = s2_valid_q;
    if (pix_valid_i) s2_valid_d = 1'b1;
    else if (s2_move) s2_valid_d = 1'b0;
    out_valid_d = out_valid_q;
    if (s2_move) out_valid_d = 1'b1;
    else if (res_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: pixel info alongside the read, then the finished result
  always_ff @(posedge clk_i) begin
    if (pix_valid_i) s2_pix_q <= pix_i;
    if (s2_move) begin
      out_res_q.cyan          <= rdata_i[2*p2p_pkg::COLOR_W +: p2p_pkg::COLOR_W];
      out_res_q.magenta       <= rdata_i[p2p_pkg::COLOR_W +: p2p_pkg::COLOR_W];
      out_res_q.yellow        <= rdata_i[0 +: p2p_pkg::COLOR_W];
      out_res_q.dest_address  <= s2_pix_q.addr;
      out_res_q.last_of_group <= s2_pix_q.last_of_group;
      out_res_q.last_of_block <= s2_pix_q.last_of_block;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_res_q;

endmodule

// File: hw/rtl/planar_to_palette_cmy_converter.sv
// Top level of the planar to palette CMY converter: configuration registers,
// row base product, palette RAM, sequencer and output stage.
// Depends on p2p_pkg, p2p_in_if, p2p_out_if, p2p_ram, p2p_seq, p2p_out.
//
// Usage:
//   req_i carries either a palette write (one 24-bit CMY entry) or a plane
//   group (one byte of each of eight planes). res_o carries one pixel per
//   handshake: cyan, magenta, yellow, destination address and last flags.
//   Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i while the
//   block is idle; any write to a known register restarts the block walk.
// Timing:
//   A palette write occupies the sequencer and gives no result. A plane
//   group gives min(8, pixels left in the row) pixels, one palette RAM read
//   per cycle while the read stage is ready; the single RAM read port sets
//   this rate. The next request is taken in the cycle its predecessor issues
//   its last access. Pixels pass the read stage and output register to res_o.
// Reset:
//   Configuration returns to defaults, position counters to zero; palette
//   contents are undefined until written.
// Stall:
//   When res_o is stalled, up to two pixels wait in the read stage and the
//   output register, then a plane group in the sequencer and req_i hold.
module planar_to_palette_cmy_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [p2p_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [p2p_pkg::CFG_DATA_W-1:0] cfg_data_i,
  p2p_in_if.sink                         req_i,
  p2p_out_if.source                      res_o
);

  logic                        order_q;
  logic [p2p_pkg::BW_W-1:0]    bw_q;
  logic [p2p_pkg::BW_W-1:0]    bh_q;
  logic [p2p_pkg::POS_W-1:0]   dx_q;
  logic [p2p_pkg::POS_W-1:0]   dy_q;
  logic [p2p_pkg::BW_W-1:0]    lw_q;
  logic                        cnt_clr;
  p2p_pkg::cfg_t               cfg;

  logic [p2p_pkg::POS_W+p2p_pkg::BW_W-1:0] prod_full;
  logic [p2p_pkg::ADDR_W-1:0]              prod_q;

  logic                          ram_we;
  logic [p2p_pkg::PAL_IDX_W-1:0] ram_waddr;
  logic [p2p_pkg::PAL_W-1:0]     ram_wdata;
  logic                          ram_re;
  logic [p2p_pkg::PAL_IDX_W-1:0] ram_raddr;
  logic [p2p_pkg::PAL_W-1:0]     ram_rdata;
  logic                          pix_valid;
  p2p_pkg::pix_t                 pix;
  logic                          s2_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
      bw_q    <= p2p_pkg::BW_W'(1);
      bh_q    <= p2p_pkg::BW_W'(1);
      dx_q    <= '0;
      dy_q    <= '0;
      lw_q    <= p2p_pkg::BW_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        p2p_pkg::CFG_PLANE_ORDER:     order_q <= cfg_data_i[0];
        p2p_pkg::CFG_BLOCK_WIDTH:     bw_q    <= cfg_data_i[p2p_pkg::BW_W-1:0];
        p2p_pkg::CFG_BLOCK_HEIGHT:    bh_q    <= cfg_data_i[p2p_pkg::BW_W-1:0];
        p2p_pkg::CFG_DEST_X:          dx_q    <= cfg_data_i[p2p_pkg::POS_W-1:0];
        p2p_pkg::CFG_DEST_Y:          dy_q    <= cfg_data_i[p2p_pkg::POS_W-1:0];
        p2p_pkg::CFG_DEST_LINE_WIDTH: lw_q    <= cfg_data_i[p2p_pkg::BW_W-1:0];
        default: ;
      endcase
    end
  end

  // a write to a known register restarts the walk
  always_comb begin
    unique case (cfg_idx_i)
      p2p_pkg::CFG_PLANE_ORDER, p2p_pkg::CFG_BLOCK_WIDTH, p2p_pkg::CFG_BLOCK_HEIGHT,
      p2p_pkg::CFG_DEST_X, p2p_pkg::CFG_DEST_Y,
      p2p_pkg::CFG_DEST_LINE_WIDTH: cnt_clr = cfg_we_i;
      default:                      cnt_clr = 1'b0;
    endcase
  end

  assign cfg.plane_order = order_q;
  assign cfg.block_w     = p2p_pkg::clamp_dim(bw_q);
  assign cfg.block_h     = p2p_pkg::clamp_dim(bh_q);
  assign cfg.dest_x      = dx_q;
  assign cfg.line_w      = lw_q;

  // address of the block's top row, registered after the multiply
  assign prod_full = dy_q * lw_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[p2p_pkg::ADDR_W-1:0];
  end

  p2p_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cnt_clr_i   (cnt_clr),
    .base_i      (prod_q),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.req),
    .s2_ready_i  (s2_ready),
    .pix_valid_o (pix_valid),
    .pix_o       (pix),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr)
  );

  p2p_ram #(
    .WIDTH (p2p_pkg::PAL_W),
    .DEPTH (p2p_pkg::PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  p2p_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_valid),
    .pix_i       (pix),
    .rdata_i     (ram_rdata),
    .s2_ready_o  (s2_ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res_o.res)
  );

`ifndef SYNTHESIS
  // the sequencer never reads and writes the palette in one cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("palette read and write in the same cycle");

  // an accepted palette write reaches the RAM in the next cycle
  a_pal_write_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready && (req_i.req.operation == p2p_pkg::OP_PAL_WRITE))
    |=> ram_we)
    else $error("palette write request not performed");

  // the end of a block is also the end of a group
  a_block_end_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.res.last_of_block) |-> res_o.res.last_of_group)
    else $error("last_of_block without last_of_group");
`endif

endmodule
